// File: design/wfe_pkg.sv
// Shared types and constants for the windowed feed-forward echo core.
// No dependencies; the top level imports it.
package wfe_pkg;

    // Payload and register widths
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int WIN_W    = 24;
    localparam int DELAY_W  = 13;
    localparam int BUFLEN_W = 25;
    localparam int CFG_W    = 25;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W   = SAMPLE_W + GAIN_W;
    localparam int ACC_W    = PROD_W + 1;
    localparam int FRAC_SH  = 14;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIN_START  = 3'd0,
        CFG_WIN_END    = 3'd1,
        CFG_DELAY      = 3'd2,
        CFG_DECAY      = 3'd3,
        CFG_BUF_LENGTH = 3'd4
    } t_cfg_idx;

    // Reset values of the configuration registers
    localparam logic [BUFLEN_W-1:0] BUF_LENGTH_RST = 25'd1;

    // Q1.15 saturation limits
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

endpackage

// File: design/windowed_feedforward_echo_core.sv
// Windowed feed-forward echo: delay memory, window control and Q1.15 mixer.
// Depends on wfe_pkg and wfe_ram.
//
// Throughput: one item per cycle while i_ready is high; a low i_ready stalls
// the pipeline. Set by the single delay-memory read and write per item and the
// three-stage read, multiply and mix (add, round, clamp) pipeline.
// Reset: configuration returns to defaults, write pointer and position go to
// zero, pipeline empties. The delay memory is not cleared.
module windowed_feedforward_echo_core #(
    parameter int MAX_DELAY  = 4096,
    parameter int INDEX_BITS = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_wr_en,
    input  logic [wfe_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [wfe_pkg::CFG_W-1:0]             i_cfg_wdata,
    // input item
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [wfe_pkg::SAMPLE_W-1:0]   i_sample_in,
    input  logic                                  i_buffer_last,
    // result item
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [wfe_pkg::SAMPLE_W-1:0]   o_sample_out,
    output logic                                  o_params_invalid,
    output logic                                  o_out_last
);

    import wfe_pkg::*;

    localparam int PTR_W = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int DW    = $clog2(MAX_DELAY + 1);
    localparam int SAT_W = (DW > DELAY_W) ? DW : DELAY_W;
    localparam int AW    = SAT_W + 1;
    localparam int CMP_W = ((INDEX_BITS > BUFLEN_W) ? INDEX_BITS : BUFLEN_W) + 1;

    // Configuration registers
    logic [WIN_W-1:0]           r_win_start;
    logic [WIN_W-1:0]           r_win_end;
    logic [DELAY_W-1:0]         r_delay;
    logic signed [GAIN_W-1:0]   r_decay;
    logic [BUFLEN_W-1:0]        r_buf_length;

    // Stream state
    logic [PTR_W-1:0]           r_wp;
    logic [PTR_W-1:0]           n_wp;
    logic [INDEX_BITS-1:0]      r_pos;
    logic [INDEX_BITS-1:0]      n_pos;

    // Pipeline registers
    logic                       r1_valid, r2_valid, r3_valid;
    logic signed [SAMPLE_W-1:0] r1_cur, r2_cur;
    logic                       r1_last, r2_last, r3_last;
    logic                       r1_inv, r2_inv, r3_inv;
    logic                       r1_mix, r2_mix;
    logic signed [PROD_W-1:0]   r2_prod;
    logic signed [SAMPLE_W-1:0] r3_sample;

    logic                       en1, en2, en3, accept;
    logic [SAT_W-1:0]           d_sat;
    logic [AW-1:0]              wp_ext, rd_ext;
    logic [PTR_W-1:0]           rd_addr;
    logic [SAMPLE_W-1:0]        mem_rd;
    logic signed [SAMPLE_W-1:0] past;
    logic                       invalid, in_window;
    logic [CMP_W-1:0]           pos_c, start_c, end_c, len_c, lo_c, lim_c;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-FRAC_SH-1:0] quo;
    logic signed [SAMPLE_W-1:0] mixed;

    // Stall control: each stage moves when the next is empty or moving
    assign en3    = !r3_valid || i_ready;
    assign en2    = !r2_valid || en3;
    assign en1    = !r1_valid || en2;
    assign o_ready = en1;
    assign accept = i_valid && en1;

    // Saturate the delay to the memory depth and form the tap address
    always_comb begin
        if (SAT_W'(r_delay) > SAT_W'(MAX_DELAY)) begin
            d_sat = SAT_W'(MAX_DELAY);
        end else begin
            d_sat = SAT_W'(r_delay);
        end
        wp_ext = AW'(r_wp);
        if (wp_ext >= AW'(d_sat)) begin
            rd_ext = wp_ext - AW'(d_sat);
        end else begin
            rd_ext = wp_ext + AW'(MAX_DELAY) - AW'(d_sat);
        end
        rd_addr = rd_ext[PTR_W-1:0];
    end

    // Window and parameter checks on the incoming item
    always_comb begin
        pos_c   = CMP_W'(r_pos);
        start_c = CMP_W'(r_win_start);
        end_c   = CMP_W'(r_win_end);
        len_c   = CMP_W'(r_buf_length);
        lo_c    = start_c + CMP_W'(d_sat);
        lim_c   = start_c + CMP_W'(r_delay);
        invalid = (end_c < start_c) || (lim_c >= len_c) || (end_c >= len_c);
        in_window = (pos_c >= lo_c) && (pos_c <= end_c);
    end

    // Advance write pointer and buffer position
    always_comb begin
        n_wp  = (r_wp == PTR_W'(MAX_DELAY - 1)) ? '0 : r_wp + PTR_W'(1);
        n_pos = i_buffer_last ? '0 : r_pos + INDEX_BITS'(1);
    end

    wfe_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_DELAY)
    ) u_delay_ram (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (r_wp),
        .i_wr_data (i_sample_in),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (mem_rd)
    );

    // Zero delay taps the current sample itself
    assign past = (r_delay == '0) ? r1_cur : $signed(mem_rd);

    // Add the scaled current sample to the echo product, round half up, shift down and saturate
    always_comb begin
        acc = (ACC_W'(r2_cur) <<< FRAC_SH) + ACC_W'(r2_prod)
            + ACC_W'(1 << (FRAC_SH - 1));
        quo = acc[ACC_W-1:FRAC_SH];
        if (quo > (ACC_W-FRAC_SH)'(SAMPLE_MAX)) begin
            mixed = SAMPLE_MAX;
        end else if (quo < (ACC_W-FRAC_SH)'(SAMPLE_MIN)) begin
            mixed = SAMPLE_MIN;
        end else begin
            mixed = quo[SAMPLE_W-1:0];
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_start  <= '0;
            r_win_end    <= '0;
            r_delay      <= '0;
            r_decay      <= '0;
            r_buf_length <= BUF_LENGTH_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WIN_START:  r_win_start  <= i_cfg_wdata[WIN_W-1:0];
                CFG_WIN_END:    r_win_end    <= i_cfg_wdata[WIN_W-1:0];
                CFG_DELAY:      r_delay      <= i_cfg_wdata[DELAY_W-1:0];
                CFG_DECAY:      r_decay      <= $signed(i_cfg_wdata[GAIN_W-1:0]);
                CFG_BUF_LENGTH: r_buf_length <= i_cfg_wdata[BUFLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_pos    <= '0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_wp  <= n_wp;
                r_pos <= n_pos;
            end
            if (en1) begin
                r1_valid <= i_valid;
            end
            if (en2) begin
                r2_valid <= r1_valid;
            end
            if (en3) begin
                r3_valid <= r2_valid;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        // stage 1: item captured alongside the memory read
        if (accept) begin
            r1_cur  <= i_sample_in;
            r1_last <= i_buffer_last;
            r1_inv  <= invalid;
            r1_mix  <= !invalid && in_window;
        end
        // stage 2: echo product
        if (en2) begin
            r2_prod <= past * r_decay;
            r2_cur  <= r1_cur;
            r2_last <= r1_last;
            r2_inv  <= r1_inv;
            r2_mix  <= r1_mix;
        end
        // stage 3: mix or pass through
        if (en3) begin
            r3_sample <= r2_mix ? mixed : r2_cur;
            r3_last   <= r2_last;
            r3_inv    <= r2_inv;
        end
    end

    assign o_valid          = r3_valid;
    assign o_sample_out     = r3_sample;
    assign o_params_invalid = r3_inv;
    assign o_out_last       = r3_last;

    // Invalid parameters never mix
    a_inv_no_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_valid && r1_inv |-> !r1_mix)
        else $error("mix flagged on an item with invalid parameters");

    // Write pointer moves only on an accepted item
    a_wp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_wp))
        else $error("write pointer moved without an item");

    // Write pointer steps by one
    a_wp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (r_wp != PTR_W'(MAX_DELAY - 1)) |=> r_wp == $past(r_wp) + PTR_W'(1))
        else $error("write pointer did not step by one");

    // Position restarts after the last item of a buffer
    a_pos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_buffer_last |=> r_pos == '0)
        else $error("position not cleared after buffer end");

    // An empty first stage always takes an item
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r1_valid |-> o_ready)
        else $error("input stalled with first stage empty");

endmodule

// File: design/wfe_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Read-first on an address collision. No dependencies.
module wfe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write and registered read share one clock
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
